### rtl/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg: shared types and constants for the frame parser
// Status and command codes, configuration bundle, result bundle.
// ----------------------------------------------------------------------------
package pls_pkg;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_GM  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_GC  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_SC  = 8'd3;

  // status codes
  localparam logic [1:0] ST_PROGRESS = 2'd0;
  localparam logic [1:0] ST_OK       = 2'd1;
  localparam logic [1:0] ST_BAD_PRE  = 2'd2;
  localparam logic [1:0] ST_BAD_CHK  = 2'd3;

  // command kinds
  localparam logic [1:0] KIND_GET_MEAS = 2'd0;
  localparam logic [1:0] KIND_GET_CFG  = 2'd1;
  localparam logic [1:0] KIND_SET_CFG  = 2'd2;
  localparam logic [1:0] KIND_UNKNOWN  = 2'd3;

  // reset values of the registers
  localparam logic [31:0] PREAMBLE_RST = 32'h0000_0000;
  localparam logic [7:0]  CODE_GM_RST  = 8'd0;
  localparam logic [7:0]  CODE_GC_RST  = 8'd1;
  localparam logic [7:0]  CODE_SC_RST  = 8'd2;

  typedef struct packed {
    logic [31:0] preamble_word;
    logic [7:0]  code_get_measurement;
    logic [7:0]  code_get_configuration;
    logic [7:0]  code_set_configuration;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  command_kind;
    logic [7:0]  command_byte;
    logic [15:0] payload_length;
    logic [7:0]  payload_byte;
    logic        payload_valid;
  } res_t;

  // first match wins: get measurement, get configuration, set configuration
  function automatic logic [1:0] classify(input logic [7:0] cmd, input cfg_t cfg);
    logic [1:0] kind;
    if (cmd == cfg.code_get_measurement) begin
      kind = KIND_GET_MEAS;
    end else if (cmd == cfg.code_get_configuration) begin
      kind = KIND_GET_CFG;
    end else if (cmd == cfg.code_set_configuration) begin
      kind = KIND_SET_CFG;
    end else begin
      kind = KIND_UNKNOWN;
    end
    return kind;
  endfunction

endpackage

### rtl/pls_cfg_regs.sv
// ----------------------------------------------------------------------------
// pls_cfg_regs: configuration register file
// Four write-only registers; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module pls_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [pls_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [pls_pkg::CFG_DATA_W-1:0] wr_data,
  output pls_pkg::cfg_t                cfg
);
  import pls_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_PREAMBLE: cfg_nxt.preamble_word          = wr_data;
        REG_CODE_GM:  cfg_nxt.code_get_measurement   = wr_data[7:0];
        REG_CODE_GC:  cfg_nxt.code_get_configuration = wr_data[7:0];
        REG_CODE_SC:  cfg_nxt.code_set_configuration = wr_data[7:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.preamble_word          <= PREAMBLE_RST;
      cfg_r.code_get_measurement   <= CODE_GM_RST;
      cfg_r.code_get_configuration <= CODE_GC_RST;
      cfg_r.code_set_configuration <= CODE_SC_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/pls_parser.sv
// ----------------------------------------------------------------------------
// pls_parser: frame parse state and per-byte decode
// Holds the frame phase, running sum and header fields; computes the result
// for the byte presented and advances the state when that byte is taken.
// ----------------------------------------------------------------------------
module pls_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic [7:0]    rx_byte,
  input  pls_pkg::cfg_t cfg,
  output pls_pkg::res_t res
);
  import pls_pkg::*;

  localparam logic [2:0] PH_PRE  = 3'd0;
  localparam logic [2:0] PH_CMD  = 3'd1;
  localparam logic [2:0] PH_LENH = 3'd2;
  localparam logic [2:0] PH_LENL = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_CHKH = 3'd5;
  localparam logic [2:0] PH_CHKL = 3'd6;

  logic [2:0]  phase_r,   phase_nxt;
  logic [1:0]  pre_idx_r, pre_idx_nxt;
  logic [7:0]  cmd_r,     cmd_nxt;
  logic [15:0] len_r,     len_nxt;
  logic [15:0] remain_r,  remain_nxt;
  logic [15:0] sum_r,     sum_nxt;
  logic [7:0]  chk_hi_r,  chk_hi_nxt;
  logic [7:0]  expect_byte;

  always_comb begin
    case (pre_idx_r)
      2'd0:    expect_byte = cfg.preamble_word[31:24];
      2'd1:    expect_byte = cfg.preamble_word[23:16];
      2'd2:    expect_byte = cfg.preamble_word[15:8];
      default: expect_byte = cfg.preamble_word[7:0];
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    pre_idx_nxt = pre_idx_r;
    cmd_nxt    = cmd_r;
    len_nxt    = len_r;
    remain_nxt = remain_r;
    sum_nxt    = sum_r;
    chk_hi_nxt = chk_hi_r;
    res.status        = ST_PROGRESS;
    res.command_kind  = KIND_GET_MEAS;
    res.payload_byte  = 8'd0;
    res.payload_valid = 1'b0;

    unique case (phase_r)
      PH_PRE: begin
        if (rx_byte != expect_byte) begin
          // mismatching byte is dropped, not retried as a first byte
          res.status  = ST_BAD_PRE;
          pre_idx_nxt = 2'd0;
        end else if (pre_idx_r == 2'd3) begin
          pre_idx_nxt = 2'd0;
          phase_nxt   = PH_CMD;
        end else begin
          pre_idx_nxt = pre_idx_r + 2'd1;
        end
      end
      PH_CMD: begin
        cmd_nxt   = rx_byte;
        sum_nxt   = {8'd0, rx_byte};
        phase_nxt = PH_LENH;
      end
      PH_LENH: begin
        len_nxt   = {rx_byte, 8'd0};
        sum_nxt   = sum_r + {rx_byte, 8'd0};
        phase_nxt = PH_LENL;
      end
      PH_LENL: begin
        len_nxt    = {len_r[15:8], rx_byte};
        sum_nxt    = sum_r + {8'd0, rx_byte};
        remain_nxt = {len_r[15:8], rx_byte};
        phase_nxt  = ({len_r[15:8], rx_byte} == 16'd0) ? PH_CHKH : PH_DATA;
      end
      PH_DATA: begin
        sum_nxt           = sum_r + {8'd0, rx_byte};
        res.payload_byte  = rx_byte;
        res.payload_valid = 1'b1;
        remain_nxt        = remain_r - 16'd1;
        if (remain_r == 16'd1) begin
          phase_nxt = PH_CHKH;
        end
      end
      PH_CHKH: begin
        chk_hi_nxt = rx_byte;
        phase_nxt  = PH_CHKL;
      end
      PH_CHKL: begin
        if ({chk_hi_r, rx_byte} == sum_r) begin
          res.status       = ST_OK;
          res.command_kind = classify(cmd_r, cfg);
        end else begin
          res.status = ST_BAD_CHK;
        end
        phase_nxt = PH_PRE;
      end
      default: begin
        phase_nxt   = PH_PRE;
        pre_idx_nxt = 2'd0;
      end
    endcase

    res.command_byte   = cmd_nxt;
    res.payload_length = len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_PRE;
      pre_idx_r <= 2'd0;
      cmd_r     <= 8'd0;
      len_r     <= 16'd0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      pre_idx_r <= pre_idx_nxt;
      cmd_r     <= cmd_nxt;
      len_r     <= len_nxt;
    end
  end

  // set before they are read within a frame, no reset needed
  always_ff @(posedge clk) begin
    if (step) begin
      remain_r <= remain_nxt;
      sum_r    <= sum_nxt;
      chk_hi_r <= chk_hi_nxt;
    end
  end

endmodule

### rtl/preamble_length_sum_frame_parser.sv
// ----------------------------------------------------------------------------
// preamble_length_sum_frame_parser: byte-stream frame parser
// Path: byte registered in the input reg, then its result in the result reg.
// Throughput: 1 byte per cycle while out_stall is low; the parse state
// updates as each byte moves from the input register to the result register.
// Reset: synchronous active-low rst_n; parse restarts at the first preamble
// byte, command/length read as zero, code registers take 0, 1, 2.
// ----------------------------------------------------------------------------
module preamble_length_sum_frame_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  // byte input request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_rx_byte,
  // result request channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [1:0]                    out_command_kind,
  output logic [7:0]                    out_command_byte,
  output logic [15:0]                   out_payload_length,
  output logic [7:0]                    out_payload_byte,
  output logic                          out_payload_valid,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pls_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pls_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t res_r;

  logic       in_vld_r;   // input register holds a byte
  logic [7:0] in_byte_r;
  logic       out_vld_r;
  logic       out_load;   // result register can take a new result
  logic       step;       // byte in input register is parsed this cycle

  // Config writes are always taken; the contract keeps them to idle time.
  assign cfg_ready = 1'b1;

  pls_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Result register frees up when empty or being drained this cycle.
  assign out_load = !out_vld_r || !out_stall;
  assign step     = in_vld_r && out_load;
  // Input register accepts when empty or when its byte moves on now.
  assign in_stall = in_vld_r && !out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte_r <= in_rx_byte;
    end
  end

  pls_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_byte_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_status         = res_r.status;
  assign out_command_kind   = res_r.command_kind;
  assign out_command_byte   = res_r.command_byte;
  assign out_payload_length = res_r.payload_length;
  assign out_payload_byte   = res_r.payload_byte;
  assign out_payload_valid  = res_r.payload_valid;

endmodule

### tb/tb_preamble_length_sum_frame_parser.sv
// ----------------------------------------------------------------------------
// tb_preamble_length_sum_frame_parser: self-checking bench for the frame parser
// Feeds a byte stream through the input channel: a short directed table, then
// random frames, broken preambles, bad check words and line noise, over four
// idling phases and several register settings. Every byte yields one result,
// which is predicted in the bench and compared field by field.
// ----------------------------------------------------------------------------
module tb_preamble_length_sum_frame_parser;
  import pls_pkg::*;

  // handshake pacing and run limits
  localparam int unsigned PHASE_BYTES    = 307;   // minimum random bytes per idling phase
  localparam int unsigned HOLD_CYCLES    = 60;    // long receiver hold-off
  localparam int unsigned LAT_CYCLES     = 4;     // pause after the last result
  localparam int unsigned TAIL_CYCLES    = 20;    // quiet time before the verdict
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no request moving

  // an index past the register file; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_OUT_OF_RANGE = 8'd4;

  typedef enum logic {ROW_BYTE, ROW_REG} step_kind_t;

  // one line of the directed table: a byte (with or without a typed-in
  // result) or a register write
  typedef struct packed {
    step_kind_t             kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    logic                   typed;
    res_t                   want;
  } step_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            in_rx_byte;
  logic                  out_valid;
  logic                  out_stall;
  logic [1:0]            out_status;
  logic [1:0]            out_command_kind;
  logic [7:0]            out_command_byte;
  logic [15:0]           out_payload_length;
  logic [7:0]            out_payload_byte;
  logic                  out_payload_valid;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  preamble_length_sum_frame_parser u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_command_kind   (out_command_kind),
    .out_command_byte   (out_command_byte),
    .out_payload_length (out_payload_length),
    .out_payload_byte   (out_payload_byte),
    .out_payload_valid  (out_payload_valid),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Parser shadow: registers and parse state as the block should hold them
  // --------------------------------------------------------------------------
  cfg_t        cfg_shadow;
  logic [16:0] pos_q;       // position of the next byte within the frame
  logic [7:0]  cmd_q;
  logic [15:0] len_q;
  logic [7:0]  chk_hi_q;
  logic [15:0] sum_q;       // running 16-bit check sum

  res_t        frame_results_due[$];   // predicted results, oldest first
  int unsigned mismatches;
  int unsigned bytes_sent;
  int unsigned reg_writes;
  int unsigned n_ok, n_bad_pre, n_bad_chk, n_payload, n_results;
  logic [3:0]  kinds_seen;

  // pacing knobs, owned by the main sequence
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_request;

  // what the byte now on the input port expects, when typed in by the table
  logic        cur_typed;
  res_t        cur_want;

  function automatic logic [7:0] pre_byte(input int unsigned i);
    return cfg_shadow.preamble_word[8*(3-i) +: 8];
  endfunction

  // first matching code wins, in register order
  function automatic logic [1:0] kind_of(input logic [7:0] c);
    if (c == cfg_shadow.code_get_measurement)   return KIND_GET_MEAS;
    if (c == cfg_shadow.code_get_configuration) return KIND_GET_CFG;
    if (c == cfg_shadow.code_set_configuration) return KIND_SET_CFG;
    return KIND_UNKNOWN;
  endfunction

  // Advance the shadow parse by one byte and return the result it gives.
  // Positions: 0..3 preamble, 4 command, 5/6 length, then payload, then the
  // two check word bytes.
  function automatic res_t parse_byte(input logic [7:0] b);
    res_t        r;
    int unsigned p;
    logic [15:0] rx_check;
    r = '0;
    r.status       = ST_PROGRESS;
    r.command_kind = KIND_GET_MEAS;
    p = pos_q;
    if (p < 4) begin
      // a wrong preamble byte restarts at position 0 and is itself dropped
      if (b != pre_byte(p)) begin
        r.status = ST_BAD_PRE;
        p = 0;
      end else begin
        p++;
      end
    end else if (p == 4) begin
      cmd_q = b;
      sum_q = {8'h00, b};
      p++;
    end else if (p == 5) begin
      len_q = {b, 8'h00};
      sum_q = sum_q + {b, 8'h00};
      p++;
    end else if (p == 6) begin
      len_q = len_q + {8'h00, b};
      sum_q = sum_q + {8'h00, b};
      p++;
    end else if (p < 7 + len_q) begin
      sum_q = sum_q + {8'h00, b};
      r.payload_byte  = b;
      r.payload_valid = 1'b1;
      p++;
    end else if (p == 7 + len_q) begin
      chk_hi_q = b;
      p++;
    end else begin
      rx_check = {chk_hi_q, b};
      if (rx_check == sum_q) begin
        r.status       = ST_OK;
        r.command_kind = kind_of(cmd_q);
      end else begin
        r.status = ST_BAD_CHK;
      end
      p = 0;
    end
    pos_q = p[16:0];
    r.command_byte   = cmd_q;
    r.payload_length = len_q;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table rows
  // --------------------------------------------------------------------------
  function automatic step_row_t plain_byte(input logic [7:0] b);
    step_row_t s;
    s = '0;
    s.kind = ROW_BYTE;
    s.data = {24'h0, b};
    return s;
  endfunction

  function automatic step_row_t known_byte(input logic [7:0] b, input logic [1:0] st,
                                           input logic [1:0] kind, input logic [7:0] cmd,
                                           input logic [15:0] len);
    step_row_t s;
    s = plain_byte(b);
    s.typed = 1'b1;
    s.want.status         = st;
    s.want.command_kind   = kind;
    s.want.command_byte   = cmd;
    s.want.payload_length = len;
    return s;
  endfunction

  function automatic step_row_t reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    step_row_t s;
    s = '0;
    s.kind = ROW_REG;
    s.idx  = idx;
    s.data = data;
    return s;
  endfunction

  step_row_t directed_steps[29];

  initial begin
    directed_steps = '{
      // after reset: preamble all zero, codes 0/1/2; zero-length frame whose
      // check word is off by one
      known_byte(8'h00, ST_PROGRESS, KIND_GET_MEAS, 8'h00, 16'h0000),
      known_byte(8'h00, ST_PROGRESS, KIND_GET_MEAS, 8'h00, 16'h0000),
      known_byte(8'h00, ST_PROGRESS, KIND_GET_MEAS, 8'h00, 16'h0000),
      known_byte(8'h00, ST_PROGRESS, KIND_GET_MEAS, 8'h00, 16'h0000),
      known_byte(8'h00, ST_PROGRESS, KIND_GET_MEAS, 8'h00, 16'h0000),
      known_byte(8'h00, ST_PROGRESS, KIND_GET_MEAS, 8'h00, 16'h0000),
      known_byte(8'h00, ST_PROGRESS, KIND_GET_MEAS, 8'h00, 16'h0000),
      known_byte(8'h00, ST_PROGRESS, KIND_GET_MEAS, 8'h00, 16'h0000),
      known_byte(8'h01, ST_BAD_CHK,  KIND_GET_MEAS, 8'h00, 16'h0000),
      known_byte(8'hFF, ST_BAD_PRE,  KIND_GET_MEAS, 8'h00, 16'h0000),
      // extreme codes, two equal; a write past the register file that would
      // wreck the preamble if it aliased onto it
      reg_write(REG_PREAMBLE, 32'hA55A_5A5A),
      reg_write(REG_CODE_GM, 32'h0000_00FF),
      reg_write(REG_CODE_GC, 32'h0000_00FF),
      reg_write(REG_CODE_SC, 32'h0000_0000),
      reg_write(REG_OUT_OF_RANGE, 32'hFFFF_FFFF),
      // the breaking byte equals the first preamble byte but must not restart
      plain_byte(8'hA5),
      known_byte(8'hA5, ST_BAD_PRE, KIND_GET_MEAS, 8'h00, 16'h0000),
      known_byte(8'h5A, ST_BAD_PRE, KIND_GET_MEAS, 8'h00, 16'h0000),
      // good frame, command 0xFF hits both equal codes, length 2
      plain_byte(8'hA5),
      plain_byte(8'h5A),
      plain_byte(8'h5A),
      plain_byte(8'h5A),
      known_byte(8'hFF, ST_PROGRESS, KIND_GET_MEAS, 8'hFF, 16'h0000),
      known_byte(8'h00, ST_PROGRESS, KIND_GET_MEAS, 8'hFF, 16'h0000),
      plain_byte(8'h02),
      plain_byte(8'hFF),
      plain_byte(8'h00),
      plain_byte(8'h02),
      known_byte(8'h00, ST_OK, KIND_GET_MEAS, 8'hFF, 16'h0002)
    };
  end

  // --------------------------------------------------------------------------
  // Input side. All driving happens right after a falling edge; the main
  // sequence always returns to a falling edge between tasks.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                           input res_t want = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_rx_byte = b;
    cur_typed  = typed;
    cur_want   = want;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    @(negedge clk);
  endtask

  // stop offering bytes until every predicted result has been taken
  task automatic drain();
    in_valid = 1'b0;
    while (frame_results_due.size() != 0) @(negedge clk);
    repeat (LAT_CYCLES) @(negedge clk);
  endtask

  // only called with nothing in flight
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PREAMBLE: cfg_shadow.preamble_word          = data;
      REG_CODE_GM:  cfg_shadow.code_get_measurement   = data[7:0];
      REG_CODE_GC:  cfg_shadow.code_get_configuration = data[7:0];
      REG_CODE_SC:  cfg_shadow.code_set_configuration = data[7:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // whole frame; corrupt flips bits of the check word
  task automatic send_frame(input logic [7:0] cmd, input logic [15:0] len,
                            input logic corrupt);
    logic [15:0] sum;
    logic [7:0]  b;
    sum = {8'h00, cmd} + len;
    for (int i = 0; i < 4; i++) send_byte(pre_byte(i));
    send_byte(cmd);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(255));
      sum = sum + {8'h00, b};
      send_byte(b);
    end
    if (corrupt) sum = sum ^ 16'($urandom_range(65535, 1));
    send_byte(sum[15:8]);
    send_byte(sum[7:0]);
  endtask

  // One random chunk of stream. The parse is back at the first preamble byte
  // after each chunk: noise never matches that byte, and a broken preamble
  // always ends on a wrong byte.
  task automatic send_random_sequence();
    int unsigned pick, k;
    logic [7:0]  cmd, b;
    logic [15:0] len;
    pick = $urandom_range(99);
    if (pick < 80) begin
      case ($urandom_range(3))
        0:       cmd = cfg_shadow.code_get_measurement;
        1:       cmd = cfg_shadow.code_get_configuration;
        2:       cmd = cfg_shadow.code_set_configuration;
        default: cmd = 8'($urandom_range(255));
      endcase
      k = $urandom_range(99);
      if (k < 10)      len = 16'd0;
      else if (k < 85) len = 16'($urandom_range(8, 1));
      else if (k < 98) len = 16'($urandom_range(40, 9));
      else             len = 16'($urandom_range(300, 256));
      send_frame(cmd, len, pick >= 70);
    end else if (pick < 90) begin
      k = $urandom_range(3);
      for (int i = 0; i < k; i++) send_byte(pre_byte(i));
      send_byte(pre_byte(k) ^ 8'($urandom_range(255, 1)));
    end else begin
      repeat ($urandom_range(3, 1)) begin
        b = 8'($urandom_range(255));
        if (b == pre_byte(0)) b = b ^ 8'($urandom_range(255, 1));
        send_byte(b);
      end
    end
  endtask

  // predict each accepted byte; a typed-in table result takes the place of
  // the predicted one, while the shadow still advances
  always @(posedge clk) begin
    res_t predicted;
    if (rst_n && in_valid && !in_stall) begin
      predicted = parse_byte(in_rx_byte);
      if (cur_typed) frame_results_due.push_back(cur_want);
      else           frame_results_due.push_back(predicted);
    end
  end

  // --------------------------------------------------------------------------
  // Result side: random stalls, plus a long hold-off counted here when the
  // main sequence asks for one
  // --------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_results_due.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected, status %0d byte %0h", $time,
                 out_status, out_payload_byte);
      end else begin
        want = frame_results_due.pop_front();
        check_field("status", 16'(want.status), 16'(out_status));
        check_field("command_kind", 16'(want.command_kind), 16'(out_command_kind));
        check_field("command_byte", 16'(want.command_byte), 16'(out_command_byte));
        check_field("payload_length", want.payload_length, out_payload_length);
        check_field("payload_byte", 16'(want.payload_byte), 16'(out_payload_byte));
        check_field("payload_valid", 16'(want.payload_valid), 16'(out_payload_valid));
        n_results++;
        if (want.payload_valid) n_payload++;
        case (want.status)
          ST_OK: begin
            n_ok++;
            kinds_seen[want.command_kind] = 1'b1;
          end
          ST_BAD_PRE: n_bad_pre++;
          ST_BAD_CHK: n_bad_chk++;
          default: ;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: ends the run if no request moves on any channel for too long
  // --------------------------------------------------------------------------
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                    (cfg_valid && cfg_ready)))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: watchdog, no request moved for %0d cycles, %0d results pending",
             $time, WATCHDOG_LIMIT, frame_results_due.size());
    $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned phase_start;
    bit          paused;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_rx_byte     = 8'h00;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    cur_typed      = 1'b0;
    cur_want       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 0;
    mismatches     = 0;
    bytes_sent     = 0;
    reg_writes     = 0;
    n_ok = 0; n_bad_pre = 0; n_bad_chk = 0; n_payload = 0; n_results = 0;
    kinds_seen     = '0;
    // shadow starts in the reset state
    cfg_shadow = {PREAMBLE_RST, CODE_GM_RST, CODE_GC_RST, CODE_SC_RST};
    pos_q = '0; cmd_q = '0; len_q = '0; chk_hi_q = '0; sum_q = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table, no idling
    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == ROW_REG) begin
        drain();
        write_reg(directed_steps[i].idx, directed_steps[i].data);
      end else begin
        send_byte(directed_steps[i].data[7:0], directed_steps[i].typed,
                  directed_steps[i].want);
      end
    end

    // random phases, each with its own idling mix and register setting
    for (int phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
          write_reg(REG_PREAMBLE, $urandom);
          write_reg(REG_CODE_GM, 32'($urandom_range(255)));
          write_reg(REG_CODE_GC, 32'($urandom_range(255)));
          write_reg(REG_CODE_SC, 32'($urandom_range(255)));
        end
        1: begin
          send_idle_pct = 77; recv_stall_pct = 0;
          write_reg(REG_PREAMBLE, 32'hFFFF_FFFF);
          write_reg(REG_CODE_GM, 32'h0000_0000);
          write_reg(REG_CODE_GC, 32'h0000_00FF);
          write_reg(REG_CODE_SC, 32'h0000_0080);
        end
        2: begin
          // all three codes equal: only get measurement or unknown can show
          send_idle_pct = 0;  recv_stall_pct = 77;
          write_reg(REG_PREAMBLE, 32'h0000_0000);
          write_reg(REG_CODE_GM, 32'h0000_005C);
          write_reg(REG_CODE_GC, 32'h0000_005C);
          write_reg(REG_CODE_SC, 32'h0000_005C);
        end
        default: begin
          send_idle_pct = 33; recv_stall_pct = 33;
          write_reg(REG_PREAMBLE, $urandom);
          write_reg(REG_CODE_GM, 32'($urandom_range(255)));
          write_reg(REG_CODE_GC, {24'h0, cfg_shadow.code_get_measurement});
          write_reg(REG_CODE_SC, 32'($urandom_range(255)));
        end
      endcase

      // full-rate phase: hold the result side off so the block backs up
      if (phase == 0) hold_request = HOLD_CYCLES;

      phase_start = bytes_sent;
      paused      = 1'b0;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        if (phase == 3 && !paused && bytes_sent - phase_start >= PHASE_BYTES / 2) begin
          drain();
          paused = 1'b1;
        end
        send_random_sequence();
      end
    end

    in_valid = 1'b0;
    while (frame_results_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d bytes, %0d results checked, %0d register writes",
             bytes_sent, n_results, reg_writes);
    $display("Frames ok %0d (kinds seen %b), bad check %0d, bad preamble %0d, payload %0d",
             n_ok, kinds_seen, n_bad_chk, n_bad_pre, n_payload);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
